// ----- rtl/core/tracker_event_translator_defines.svh -----
// Assertion macros for the tracker event translator.
`ifndef TRACKER_EVENT_TRANSLATOR_DEFINES_SVH
`define TRACKER_EVENT_TRANSLATOR_DEFINES_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define TET_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked during reset too
`define TET_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define TET_ASSERT(label, prop, msg)
`define TET_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ----- rtl/core/trkevt_pkg.sv -----
// Shared types and constants for the tracker event translator.
package trkevt_pkg;

    // effect codes of the input word
    localparam logic [3:0] CODE_ARP    = 4'd0;
    localparam logic [3:0] CODE_SLUP   = 4'd1;
    localparam logic [3:0] CODE_SLDN   = 4'd2;
    localparam logic [3:0] CODE_VOL    = 4'd3;
    localparam logic [3:0] CODE_INSVOL = 4'd4;
    localparam logic [3:0] CODE_JUMP   = 4'd5;
    localparam logic [3:0] CODE_BREAK  = 4'd6;
    localparam logic [3:0] CODE_SPEED  = 4'd7;
    localparam logic [3:0] CODE_PORTA  = 4'd8;
    localparam logic [3:0] CODE_EXT    = 4'd9;

    // effect kinds of the output word
    localparam logic [3:0] KIND_NONE   = 4'd0;
    localparam logic [3:0] KIND_ARP    = 4'd1;
    localparam logic [3:0] KIND_SLUP   = 4'd2;
    localparam logic [3:0] KIND_SLDN   = 4'd3;
    localparam logic [3:0] KIND_CARVOL = 4'd4;
    localparam logic [3:0] KIND_MODVOL = 4'd5;
    localparam logic [3:0] KIND_INSVOL = 4'd6;
    localparam logic [3:0] KIND_JUMP   = 4'd7;
    localparam logic [3:0] KIND_BREAK  = 4'd8;
    localparam logic [3:0] KIND_SPEED  = 4'd9;
    localparam logic [3:0] KIND_TEMPO  = 4'd10;
    localparam logic [3:0] KIND_PORTA  = 4'd11;
    localparam logic [3:0] KIND_EXT    = 4'd12;
    localparam logic [3:0] KIND_VSLIDE = 4'd13;
    localparam logic [3:0] KIND_EXT2   = 4'd14;

    localparam logic [3:0] FINE_UP_SUBCODE   = 4'd0;
    localparam logic [3:0] FINE_DOWN_SUBCODE = 4'd1;

    localparam logic [6:0] MAX_NOTE   = 7'd96;
    localparam logic [6:0] CLAMP_63   = 7'd63;
    localparam logic [6:0] CLAMP_99   = 7'd99;
    localparam logic [6:0] TEMPO_DFLT = 7'd18;
    localparam logic [7:0] EXT_HI_ROW = 8'h10;
    // p / 10 == (p * 205) >> 11 for every 7-bit p
    localparam logic [7:0] DIV10_MUL  = 8'd205;

    // stage 1: fields decoded, tens digit found
    typedef struct packed {
        logic [4:0] instr;
        logic [6:0] note;
        logic [3:0] code;
        logic [6:0] p;
        logic [3:0] hi;
    } t_s1;

    // stage 2: digits and derived values ready
    typedef struct packed {
        logic [4:0] instr;
        logic [6:0] note;
        logic [3:0] code;
        logic [6:0] p;
        logic [3:0] hi;
        logic [3:0] lo;
        logic [7:0] bcd;
        logic [6:0] hi7;
        logic [6:0] lo7;
    } t_s2;

endpackage

// ----- rtl/core/tracker_event_translator.sv -----
// Tracker event translator: three-stage pipeline from pattern event to cell.
// The first of the three register stages is loaded at the input accept edge.
// Throughput: one word per cycle; each stage advances when the one after it is
// empty or moving, so an output stall holds the full stages and bubbles still fill.
// Reset (synchronous, i_rst_n low) clears the three stage valid bits only;
// the payload registers keep whatever they hold.
`include "tracker_event_translator_defines.svh"

module tracker_event_translator
    import trkevt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] note_octave_byte, [15:8] instr_effect_byte, [23:16] effect_param
    input  logic [23:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [4:0] instrument_number, [11:5] note_number, [15:12] effect_kind,
    // [23:16] effect_value
    output logic [23:0] o_m_axis_tdata
);

    // ---------------------------------------------------------------
    // Stage enables: a stage loads when its output slot frees up.
    // ---------------------------------------------------------------
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    assign en3 = !r_v3 || i_m_axis_tready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_s_axis_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_s_axis_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: unpack, build note, tens digit by reciprocal multiply.
    // ---------------------------------------------------------------
    logic [7:0]  in_a, in_b;
    logic [6:0]  in_p;
    logic [3:0]  semi;
    logic [2:0]  oct;
    logic [6:0]  note_c;
    logic [14:0] div_prod;
    t_s1         n_s1, r_s1;

    assign in_a     = i_s_axis_tdata[7:0];
    assign in_b     = i_s_axis_tdata[15:8];
    assign in_p     = i_s_axis_tdata[22:16];   // bit 7 of the parameter ignored
    assign semi     = in_a[7:4];
    assign oct      = in_a[3:1];
    assign div_prod = {8'd0, in_p} * {7'd0, DIV10_MUL};

    always_comb begin
        // 12 * octave = 8 * octave + 4 * octave
        note_c = '0;
        if (semi >= 4'd1 && semi <= 4'd12)
            note_c = {1'b0, oct, 3'b000} + {2'b00, oct, 2'b00} + {3'b000, semi};
        n_s1.note  = note_c;
        n_s1.instr = (note_c == '0) ? 5'd0 : {in_a[0], in_b[7:4]};
        n_s1.code  = in_b[3:0];
        n_s1.p     = in_p;
        n_s1.hi    = div_prod[14:11];
    end

    always_ff @(posedge i_clk) begin
        if (en1) r_s1 <= n_s1;
    end

    // ---------------------------------------------------------------
    // Stage 2: units digit, BCD form, digit times seven.
    // ---------------------------------------------------------------
    logic [6:0] hi10;
    logic [6:0] lo_w;
    t_s2        n_s2, r_s2;

    assign hi10 = {r_s1.hi, 3'b000} + {2'b00, r_s1.hi, 1'b0};
    assign lo_w = r_s1.p - hi10;

    always_comb begin
        n_s2.instr = r_s1.instr;
        n_s2.note  = r_s1.note;
        n_s2.code  = r_s1.code;
        n_s2.p     = r_s1.p;
        n_s2.hi    = r_s1.hi;
        n_s2.lo    = lo_w[3:0];
        n_s2.bcd   = {r_s1.hi, lo_w[3:0]};
        n_s2.hi7   = {r_s1.hi, 3'b000} - {3'b000, r_s1.hi};
        n_s2.lo7   = {lo_w[3:0], 3'b000} - {3'b000, lo_w[3:0]};
    end

    always_ff @(posedge i_clk) begin
        if (en2) r_s2 <= n_s2;
    end

    // ---------------------------------------------------------------
    // Stage 3: effect decode into the output register.
    // ---------------------------------------------------------------
    logic [3:0] n_kind, r_kind;
    logic [7:0] n_val, r_val;
    logic [4:0] r_instr;
    logic [6:0] r_note;
    logic [7:0] p8;

    assign p8 = {1'b0, r_s2.p};

    always_comb begin
        n_kind = KIND_NONE;
        n_val  = '0;
        case (r_s2.code)
            CODE_ARP: begin
                n_kind = KIND_ARP;
                n_val  = r_s2.bcd;
            end
            CODE_SLUP: begin
                n_kind = KIND_SLUP;
                n_val  = p8;
            end
            CODE_SLDN: begin
                n_kind = KIND_SLDN;
                n_val  = p8;
            end
            CODE_VOL: begin
                // two-digit value drives carrier, otherwise a nonzero units digit the modulator
                if (r_s2.p >= 7'd10 && r_s2.p <= CLAMP_99) begin
                    n_kind = KIND_CARVOL;
                    n_val  = {1'b0, r_s2.hi7};
                end else if (r_s2.lo != 4'd0) begin
                    n_kind = KIND_MODVOL;
                    n_val  = {1'b0, r_s2.lo7};
                end
            end
            CODE_INSVOL: begin
                n_kind = KIND_INSVOL;
                n_val  = {1'b0, (r_s2.p <= CLAMP_63) ? r_s2.p : CLAMP_63};
            end
            CODE_JUMP: begin
                n_kind = KIND_JUMP;
                n_val  = {1'b0, (r_s2.p <= CLAMP_99) ? r_s2.p : CLAMP_99};
            end
            CODE_BREAK: begin
                n_kind = KIND_BREAK;
                n_val  = {1'b0, (r_s2.p <= CLAMP_63) ? r_s2.p : CLAMP_63};
            end
            CODE_SPEED: begin
                if (r_s2.p < CLAMP_99) begin
                    if (r_s2.p >= 7'd1 && r_s2.p <= 7'd31) begin
                        n_kind = KIND_SPEED;
                        n_val  = p8;
                    end else begin
                        n_kind = KIND_TEMPO;
                        n_val  = {1'b0, (r_s2.p == '0) ? TEMPO_DFLT : r_s2.p};
                    end
                end
            end
            CODE_PORTA: begin
                n_kind = KIND_PORTA;
                n_val  = p8;
            end
            CODE_EXT: begin
                case (r_s2.hi)
                    4'd0: begin
                        if (r_s2.lo <= 4'd1) begin
                            n_kind = KIND_EXT;
                            n_val  = r_s2.bcd;
                        end
                    end
                    4'd1: begin
                        if (r_s2.lo <= 4'd1) begin
                            n_kind = KIND_EXT;
                            n_val  = EXT_HI_ROW + r_s2.bcd;
                        end
                    end
                    4'd2: begin
                        n_kind = KIND_VSLIDE;
                        n_val  = {r_s2.lo, 4'd0};
                    end
                    4'd3: begin
                        n_kind = KIND_VSLIDE;
                        n_val  = {4'd0, r_s2.lo};
                    end
                    4'd4: begin
                        n_kind = KIND_EXT2;
                        n_val  = {FINE_UP_SUBCODE, r_s2.lo};
                    end
                    4'd5: begin
                        n_kind = KIND_EXT2;
                        n_val  = {FINE_DOWN_SUBCODE, r_s2.lo};
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_instr <= r_s2.instr;
            r_note  <= r_s2.note;
            r_kind  <= n_kind;
            r_val   <= n_val;
        end
    end

    assign o_m_axis_tvalid = r_v3;
    assign o_m_axis_tdata  = {r_val, r_kind, r_note, r_instr};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `TET_ASSERT(a_empty_note_no_instr,
        o_m_axis_tvalid && (r_note == '0) |-> (r_instr == '0),
        "instrument set on an empty note")
    `TET_ASSERT(a_note_range, o_m_axis_tvalid |-> (r_note <= MAX_NOTE),
        "note number out of range")
    `TET_ASSERT(a_none_zero_value,
        o_m_axis_tvalid && (r_kind == KIND_NONE) |-> (r_val == '0),
        "value set without an effect")
    `TET_ASSERT(a_full_only_when_blocked,
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready),
        "input blocked while output drains")
    `TET_ASSERT_ALWAYS(a_reset_empties,
        !i_rst_n |=> !o_m_axis_tvalid,
        "output valid right after reset")

endmodule

// ----- bench/tracker_event_translator_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the tracker event translator: predicts every cell and checks the output stream.
module tracker_event_translator_checker
    import trkevt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    // [7:0] note_octave_byte, [15:8] instr_effect_byte, [23:16] effect_param
    input  logic [23:0] i_s_axis_tdata,
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [4:0] instrument_number, [11:5] note_number, [15:12] effect_kind,
    // [23:16] effect_value
    input  logic [23:0] i_m_axis_tdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int VOL_CEIL      = 63;
    localparam int POS_CEIL      = 99;
    localparam int TEMPO_DEFAULT = 18;
    localparam int SPEED_CEIL    = 31;
    localparam int EXT_ROW_HI    = 'h10;
    localparam int REPORT_LIMIT  = 10;

    // same bit layout as the output word, top field first
    typedef struct packed {
        logic [7:0] value;
        logic [3:0] kind;
        logic [6:0] note;
        logic [4:0] instr;
    } t_cell;

    typedef struct {
        logic [23:0] src;
        t_cell       pred;
    } t_queued_cell;

    t_queued_cell cell_queue[$];
    int           fails = 0;

    function automatic logic [7:0] bcd_pack(input int v);
        return 8'(((v / 10) << 4) + v % 10);
    endfunction

    function automatic t_cell translate_event(input logic [23:0] ev);
        logic [7:0] note_oct;
        logic [7:0] ins_fx;
        int         p;
        int         tens;
        int         ones;
        int         semi;
        t_cell      c;
        note_oct = ev[7:0];
        ins_fx   = ev[15:8];
        p        = ev[22:16];   // bit 7 of the parameter is dropped
        tens     = p / 10;
        ones     = p % 10;
        semi     = note_oct[7:4];
        c        = '0;
        c.instr  = {note_oct[0], ins_fx[7:4]};
        if (semi >= 1 && semi <= 12) begin
            c.note = 7'(12 * note_oct[3:1] + semi);
        end
        case (ins_fx[3:0])
            CODE_ARP: begin
                c.kind  = KIND_ARP;
                c.value = bcd_pack(p);
            end
            CODE_SLUP: begin
                c.kind  = KIND_SLUP;
                c.value = 8'(p);
            end
            CODE_SLDN: begin
                c.kind  = KIND_SLDN;
                c.value = 8'(p);
            end
            CODE_VOL: begin
                if (p >= 10 && p <= 99) begin
                    c.kind  = KIND_CARVOL;
                    c.value = 8'(tens * 7);
                end else if (ones != 0) begin
                    c.kind  = KIND_MODVOL;
                    c.value = 8'(ones * 7);
                end
            end
            CODE_INSVOL: begin
                c.kind  = KIND_INSVOL;
                c.value = 8'((p <= VOL_CEIL) ? p : VOL_CEIL);
            end
            CODE_JUMP: begin
                c.kind  = KIND_JUMP;
                c.value = 8'((p <= POS_CEIL) ? p : POS_CEIL);
            end
            CODE_BREAK: begin
                c.kind  = KIND_BREAK;
                c.value = 8'((p <= VOL_CEIL) ? p : VOL_CEIL);
            end
            CODE_SPEED: begin
                if (p < POS_CEIL) begin
                    if (p >= 1 && p <= SPEED_CEIL) begin
                        c.kind  = KIND_SPEED;
                        c.value = 8'(p);
                    end else begin
                        c.kind  = KIND_TEMPO;
                        c.value = 8'((p == 0) ? TEMPO_DEFAULT : p);
                    end
                end
            end
            CODE_PORTA: begin
                c.kind  = KIND_PORTA;
                c.value = 8'(p);
            end
            CODE_EXT: begin
                // the tens digit picks the sub-command
                case (tens)
                    0: if (ones <= 1) begin
                        c.kind  = KIND_EXT;
                        c.value = bcd_pack(p);
                    end
                    1: if (ones <= 1) begin
                        c.kind  = KIND_EXT;
                        c.value = 8'(EXT_ROW_HI + bcd_pack(p));
                    end
                    2: begin
                        c.kind  = KIND_VSLIDE;
                        c.value = 8'(ones * 16);
                    end
                    3: begin
                        c.kind  = KIND_VSLIDE;
                        c.value = 8'(ones);
                    end
                    4: begin
                        c.kind  = KIND_EXT2;
                        c.value = 8'(FINE_UP_SUBCODE * 16 + ones);
                    end
                    5: begin
                        c.kind  = KIND_EXT2;
                        c.value = 8'(FINE_DOWN_SUBCODE * 16 + ones);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (c.note == '0) begin
            c.instr = '0;
        end
        return c;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_queued_cell want;
        t_cell        got;
        if (i_rst_n) begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got = t_cell'(i_m_axis_tdata);
                if (cell_queue.size() == 0) begin
                    fails = fails + 1;
                    if (fails <= REPORT_LIMIT) begin
                        $display("%0t: unexpected cell word %h", $realtime, i_m_axis_tdata);
                    end
                end else begin
                    want = cell_queue.pop_front();
                    if (got.instr !== want.pred.instr || got.note !== want.pred.note ||
                        got.kind !== want.pred.kind || got.value !== want.pred.value) begin
                        fails = fails + 1;
                        if (fails <= REPORT_LIMIT) begin
                            $display("%0t: event %h expected instr=%0d note=%0d kind=%0d val=%h",
                                     $realtime, want.src, want.pred.instr, want.pred.note,
                                     want.pred.kind, want.pred.value);
                            $display("%0t:   got            instr=%0d note=%0d kind=%0d val=%h",
                                     $realtime, got.instr, got.note, got.kind, got.value);
                        end
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                cell_queue.push_back('{i_s_axis_tdata, translate_event(i_s_axis_tdata)});
            end
        end
        o_fail_count = fails;
        o_pending    = cell_queue.size();
    end

endmodule

// ----- bench/tracker_event_translator_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the tracker event translator: stimulus, output stalls and verdict.
module tracker_event_translator_tb;
    import trkevt_pkg::*;

    // effect codes the block does not know; they must give an empty effect
    localparam logic [3:0] CODE_UNUSED_LO = 4'd10;
    localparam logic [3:0] CODE_UNUSED_HI = 4'd15;
    localparam int         RANDOM_EVENTS  = 450;
    localparam int         IDLE_PCT       = 19;
    localparam int         SETTLE_CYCLES  = 8;    // pipeline is 3 deep, leave margin

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        ev_valid   = 1'b0;
    logic        ev_ready;
    logic [23:0] ev_data    = '0;
    logic        cell_valid;
    logic        cell_ready = 1'b0;
    logic [23:0] cell_data;

    int fail_count;
    int pending;
    int tx_idle_pct = IDLE_PCT;
    int rx_idle_pct = IDLE_PCT;

    // parameter values that sit on a digit or clamp boundary
    logic [6:0] boundary_params [0:16] = '{7'd0, 7'd1, 7'd9, 7'd10, 7'd11, 7'd19, 7'd20,
                                          7'd31, 7'd32, 7'd59, 7'd60, 7'd63, 7'd64,
                                          7'd98, 7'd99, 7'd100, 7'd127};

    tracker_event_translator dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (ev_valid),
        .o_s_axis_tready (ev_ready),
        .i_s_axis_tdata  (ev_data),
        .o_m_axis_tvalid (cell_valid),
        .i_m_axis_tready (cell_ready),
        .o_m_axis_tdata  (cell_data)
    );

    tracker_event_translator_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (ev_valid),
        .i_s_axis_tready (ev_ready),
        .i_s_axis_tdata  (ev_data),
        .i_m_axis_tvalid (cell_valid),
        .i_m_axis_tready (cell_ready),
        .i_m_axis_tdata  (cell_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // output side: drop tready at random, independent of the input side
    always @(posedge clk) begin
        cell_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Present one word and hold it until taken. Handshake is judged at the
    // falling edge, where both tvalid and tready are settled for the next
    // rising edge. Returns right after the accepting edge.
    task automatic send_word(input logic [23:0] w);
        ev_data  <= w;
        ev_valid <= 1'b1;
        do @(negedge clk); while (!ev_ready);
        @(posedge clk);
    endtask

    // one event word, then maybe a one-cycle gap on the input side
    task automatic play(input logic [7:0] note_oct, input logic [7:0] ins_fx,
                        input logic [7:0] param);
        send_word({param, ins_fx, note_oct});
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            ev_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // hold the input off until every predicted cell has come out
    task automatic wait_drained();
        ev_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    initial begin : stimulus
        logic [7:0] note_oct;
        logic [7:0] ins_fx;
        logic [7:0] param;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every effect code, its branches and the field extremes
        play(8'hCF, {4'hF, CODE_ARP}, 8'hFF);        // top note, instrument 31, p = 127
        play(8'h10, {4'h1, CODE_SLUP}, 8'h80);       // lowest note, only the ignored bit 7
        play(8'h5A, {4'h3, CODE_SLDN}, 8'h7F);
        play(8'h33, {4'h7, CODE_VOL}, 8'd55);        // carrier volume
        play(8'h44, {4'h8, CODE_VOL}, 8'd7);         // modulator volume
        play(8'h44, {4'h8, CODE_VOL}, 8'd100);       // above 99 and ones zero: nothing
        play(8'h62, {4'h2, CODE_VOL}, 8'd0);
        play(8'h7C, {4'hA, CODE_INSVOL}, 8'd64);     // clamps to 63
        play(8'h8D, {4'hB, CODE_JUMP}, 8'd120);      // clamps to 99
        play(8'h91, {4'hC, CODE_BREAK}, 8'd63);
        play(8'hA6, {4'hD, CODE_SPEED}, 8'd0);       // zero turns into the default tempo
        play(8'hB8, {4'hE, CODE_SPEED}, 8'd31);      // highest speed
        play(8'h2B, {4'h0, CODE_SPEED}, 8'd32);      // lowest tempo
        play(8'h19, {4'h4, CODE_SPEED}, 8'd99);      // out of range: nothing
        play(8'h27, {4'h5, CODE_PORTA}, 8'hCD);
        play(8'h35, {4'h6, CODE_EXT}, 8'd1);
        play(8'h35, {4'h6, CODE_EXT}, 8'd5);         // ones above 1 in the first row
        play(8'h35, {4'h6, CODE_EXT}, 8'd11);
        play(8'h35, {4'h6, CODE_EXT}, 8'd25);
        play(8'h35, {4'h6, CODE_EXT}, 8'd37);
        play(8'h35, {4'h6, CODE_EXT}, 8'd43);        // fine up
        play(8'h35, {4'h6, CODE_EXT}, 8'd58);        // fine down
        play(8'h35, {4'h6, CODE_EXT}, 8'd65);        // tens of 6 and up: nothing
        play(8'h47, {4'h9, CODE_UNUSED_LO}, 8'd12);
        play(8'h0F, {4'hF, CODE_UNUSED_HI}, 8'd20);  // empty note clears the instrument
        play(8'hDE, {4'hF, CODE_ARP}, 8'd42);        // semitone 13
        play(8'hF1, {4'h1, CODE_SLUP}, 8'd3);        // semitone 15
        wait_drained();

        // random: mostly valid notes and known codes, boundary parameters often
        for (int i = 0; i < RANDOM_EVENTS; i++) begin
            if (i == 150) begin
                tx_idle_pct = 0;                     // full-rate stretch on both sides
                rx_idle_pct = 0;
            end
            if (i == 280) begin
                tx_idle_pct = IDLE_PCT;
                rx_idle_pct = IDLE_PCT;
            end
            if (i == 320) begin
                wait_drained();
            end
            note_oct = 8'($urandom);
            if ($urandom_range(0, 99) < 85) begin
                note_oct[7:4] = 4'($urandom_range(1, 12));
            end
            ins_fx = 8'($urandom);
            if ($urandom_range(0, 99) < 88) begin
                ins_fx[3:0] = 4'($urandom_range(CODE_ARP, CODE_EXT));
            end else begin
                ins_fx[3:0] = 4'($urandom_range(CODE_UNUSED_LO, CODE_UNUSED_HI));
            end
            param = 8'($urandom);
            if ($urandom_range(0, 99) < 30) begin
                param[6:0] = boundary_params[$urandom_range(0, 16)];
            end
            play(note_oct, ins_fx, param);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("tracker_event_translator regression: pass");
        end else begin
            $display("tracker_event_translator regression: fail");
        end
        $finish;
    end

    // watchdog, far beyond any correct run
    initial begin
        #2000000;
        $display("tracker_event_translator regression: fail");
        $finish;
    end

endmodule
